// ----- hdl/csc_pkg.sv -----
package csc_pkg;

    localparam int WORD_BITS            = 16;
    localparam int DEF_CURSOR_ROWS      = 16;
    localparam int DEF_SCREEN_COL_WORDS = 256;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_COMPOSE = 1'b1;

    typedef enum logic [2:0] {
        CFG_HOT_X         = 3'd0,
        CFG_HOT_Y         = 3'd1,
        CFG_SPRITE_WIDTH  = 3'd2,
        CFG_SPRITE_HEIGHT = 3'd3,
        CFG_MAX_X         = 3'd4,
        CFG_MAX_Y         = 3'd5
    } cfg_idx_t;

    localparam logic [3:0]  RST_HOT_X         = 4'd0;
    localparam logic [3:0]  RST_HOT_Y         = 4'd0;
    localparam logic [4:0]  RST_SPRITE_WIDTH  = 5'd16;
    localparam logic [4:0]  RST_SPRITE_HEIGHT = 5'd16;
    localparam logic [11:0] RST_MAX_X         = 12'd639;
    localparam logic [11:0] RST_MAX_Y         = 12'd399;

endpackage

// ----- hdl/cursor_sprite_compose_1bpp.sv -----
// Cursor overlay for a 1bpp framebuffer stream. A load word (tuser 0) stores one
// cursor row, mask and image, and returns nothing; a compose word (tuser 1)
// returns the screen word with the clipped cursor composed in, plus a touched
// flag. Throughput is one word per clock while m_tready does not stall the output;
// a compose word is registered with the row store read and the stage 1 payload,
// then passes through the compose stage into the output register. Rows never
// loaded read as zero, so the cursor is transparent after reset.
module cursor_sprite_compose_1bpp
    import csc_pkg::*;
#(
    parameter int CURSOR_ROWS         = DEF_CURSOR_ROWS,
    parameter int SCREEN_COLUMN_WORDS = DEF_SCREEN_COL_WORDS
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [11:0] cfg_wdata,

    input  logic        s_tvalid,
    output logic        s_tready,
    // sprite_row[3:0], mask_bits[19:4], image_bits[35:20], pointer_x[47:36],
    // pointer_y[59:48], word_column[67:60], pixel_row[79:68], screen_word[95:80]
    input  logic [95:0] s_tdata,
    // action[0]
    input  logic        s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // result_word[15:0], touched[16], zero[23:17]
    output logic [23:0] m_tdata
);

    localparam int ROW_AW = (CURSOR_ROWS > 1) ? $clog2(CURSOR_ROWS) : 1;
    localparam logic [6:0]  ROWS_L = 7'(CURSOR_ROWS);
    localparam logic [10:0] COLS_L = 11'(SCREEN_COLUMN_WORDS);

    // configuration
    logic [3:0]  hot_x_reg;
    logic [3:0]  hot_y_reg;
    logic [4:0]  sprite_width_reg;
    logic [4:0]  sprite_height_reg;
    logic [11:0] max_x_reg;
    logic [11:0] max_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hot_x_reg         <= RST_HOT_X;
            hot_y_reg         <= RST_HOT_Y;
            sprite_width_reg  <= RST_SPRITE_WIDTH;
            sprite_height_reg <= RST_SPRITE_HEIGHT;
            max_x_reg         <= RST_MAX_X;
            max_y_reg         <= RST_MAX_Y;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_HOT_X:         hot_x_reg         <= cfg_wdata[3:0];
                CFG_HOT_Y:         hot_y_reg         <= cfg_wdata[3:0];
                CFG_SPRITE_WIDTH:  sprite_width_reg  <= cfg_wdata[4:0];
                CFG_SPRITE_HEIGHT: sprite_height_reg <= cfg_wdata[4:0];
                CFG_MAX_X:         max_x_reg         <= cfg_wdata;
                CFG_MAX_Y:         max_y_reg         <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input fields
    logic [3:0]  in_srow;
    logic [15:0] in_mask;
    logic [15:0] in_image;
    logic [11:0] in_px;
    logic [11:0] in_py;
    logic [7:0]  in_wcol;
    logic [11:0] in_prow;
    logic [15:0] in_dst;

    assign in_srow  = s_tdata[3:0];
    assign in_mask  = s_tdata[19:4];
    assign in_image = s_tdata[35:20];
    assign in_px    = s_tdata[47:36];
    assign in_py    = s_tdata[59:48];
    assign in_wcol  = s_tdata[67:60];
    assign in_prow  = s_tdata[79:68];
    assign in_dst   = s_tdata[95:80];

    // flow control
    logic s1_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic s1_free;
    logic s1_adv;
    logic accept;
    logic comp_acc;
    logic load_acc;

    assign out_free = !out_valid_reg || m_tready;
    assign s1_free  = !s1_valid_reg || out_free;
    assign s1_adv   = s1_valid_reg && out_free;
    assign s_tready = s1_free;
    assign accept   = s_tvalid && s_tready;
    assign comp_acc = accept && (s_tuser == ACT_COMPOSE);
    assign load_acc = accept && (s_tuser == ACT_LOAD);

    // stage 0: row lookup
    logic [6:0]        h_eff;
    logic [13:0]       sr;
    logic              sr_ok;
    logic              hit;
    logic [ROW_AW+12:0] sr_ext;
    logic [ROW_AW-1:0] raddr;
    logic [11:0]       base;
    logic [13:0]       dx;
    logic [13:0]       lim;
    logic              srow_ok;
    logic [ROW_AW+3:0] srow_ext;
    logic [ROW_AW-1:0] waddr;

    assign h_eff   = ({2'b0, sprite_height_reg} > ROWS_L) ? ROWS_L : {2'b0, sprite_height_reg};
    assign sr      = 14'(in_prow) - 14'(in_py) + 14'(hot_y_reg);
    assign sr_ok   = !sr[13] && (sr[12:0] < 13'(h_eff));
    assign hit     = ({3'b0, in_wcol} < COLS_L) && (in_prow <= max_y_reg) && sr_ok;
    assign sr_ext  = {{ROW_AW{1'b0}}, sr[12:0]};
    assign raddr   = sr_ext[ROW_AW-1:0];
    assign base    = {in_wcol, 4'b0};
    assign dx      = 14'(base) - 14'(in_px) + 14'(hot_x_reg);
    assign lim     = 14'(max_x_reg) - 14'(base);
    assign srow_ok = ({3'b0, in_srow} < ROWS_L);
    assign srow_ext = {{ROW_AW{1'b0}}, in_srow};
    assign waddr   = srow_ext[ROW_AW-1:0];

    // row store
    logic [15:0] mask_mem  [CURSOR_ROWS];
    logic [15:0] image_mem [CURSOR_ROWS];
    logic [CURSOR_ROWS-1:0] row_vld_reg;
    logic [15:0] rd_mask_reg;
    logic [15:0] rd_image_reg;
    logic        rd_ok_reg;

    always_ff @(posedge clk)
    begin
        if (load_acc && srow_ok)
        begin
            mask_mem[waddr]  <= in_mask;
            image_mem[waddr] <= in_image;
        end
        if (comp_acc)
        begin
            rd_mask_reg  <= mask_mem[raddr];
            rd_image_reg <= image_mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
            rd_ok_reg   <= 1'b0;
        end
        else
        begin
            if (load_acc && srow_ok)
            begin
                row_vld_reg[waddr] <= 1'b1;
            end
            if (comp_acc)
            begin
                rd_ok_reg <= row_vld_reg[raddr];
            end
        end
    end

    // stage 1 payload
    logic        s1_hit_reg;
    logic [13:0] s1_dx_reg;
    logic [13:0] s1_lim_reg;
    logic [15:0] s1_dst_reg;

    always_ff @(posedge clk)
    begin
        if (comp_acc)
        begin
            s1_hit_reg <= hit;
            s1_dx_reg  <= dx;
            s1_lim_reg <= lim;
            s1_dst_reg <= in_dst;
        end
    end

    // stage 1: compose
    logic [4:0]  w_eff;
    logic [15:0] mrow;
    logic [15:0] irow;
    logic [15:0] m_sel;
    logic [15:0] i_sel;
    logic        any_vis;
    logic [15:0] result_next;
    logic        touched_next;

    assign w_eff = (sprite_width_reg > 5'(WORD_BITS)) ? 5'(WORD_BITS) : sprite_width_reg;
    assign mrow  = rd_ok_reg ? rd_mask_reg  : '0;
    assign irow  = rd_ok_reg ? rd_image_reg : '0;

    always_comb
    begin
        logic [13:0] sc;
        logic        vis;
        m_sel   = '0;
        i_sel   = '0;
        any_vis = 1'b0;
        for (int p = 0; p < WORD_BITS; p++)
        begin
            sc  = s1_dx_reg + 14'(p);
            vis = ($signed(s1_lim_reg) >= $signed(14'(p))) && !sc[13]
                  && (sc[12:0] < 13'(w_eff));
            if (vis && s1_hit_reg)
            begin
                any_vis = 1'b1;
                m_sel[WORD_BITS-1-p] = mrow[4'(WORD_BITS-1) - sc[3:0]];
                i_sel[WORD_BITS-1-p] = irow[4'(WORD_BITS-1) - sc[3:0]];
            end
        end
    end

    assign result_next  = (s1_dst_reg & ~m_sel) | (i_sel & m_sel);
    assign touched_next = any_vis;

    // output register
    logic [15:0] result_reg;
    logic        touched_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= comp_acc;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            result_reg  <= result_next;
            touched_reg <= touched_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, touched_reg, result_reg};

`ifndef SYNTHESIS
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty output");

    a_compose_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == ACT_COMPOSE)) |=> s1_valid_reg)
        else $error("accepted compose word lost");

    a_miss_untouched: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && !s1_hit_reg) |=> !touched_reg)
        else $error("touched set outside cursor rows");
`endif

endmodule
